@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro expands to one labelled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/u8fw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the UTF-8 width fitter.
// No dependencies; every module of the block imports this package.
package u8fw_pkg;

    localparam int MAX_CELL_WIDTH = 255;
    localparam logic [7:0] CELL_WIDTH_RESET = 8'd22;
    localparam logic [7:0] SUBST_CHAR = 8'h3F;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW = $clog2(OUT_DEPTH);

    // Lead-byte classes, numerically the sequence length
    localparam logic [2:0] CLS_BAD = 3'd0;
    localparam logic [2:0] CLS_1   = 3'd1;
    localparam logic [2:0] CLS_2   = 3'd2;
    localparam logic [2:0] CLS_3   = 3'd3;
    localparam logic [2:0] CLS_4   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [7:0] total_width;
        logic [7:0] pad_count;
        logic       out_last;
    } t_out;

    // One decoded code point: its byte count (0 = no unit) and display width
    typedef struct packed {
        logic [2:0] len;
        logic [1:0] wid;
    } t_unit;

    // Work for the back end: the bytes of one decode run, split into units
    typedef struct packed {
        logic [3:0][7:0] bytes;
        t_unit [2:0]     units;
        logic            last;
    } t_entry;

    function automatic logic [2:0] lead_class(input logic [7:0] c);
        logic [2:0] cls;
        if (c < 8'h80) begin
            cls = CLS_1;
        end else if ((c & 8'hE0) == 8'hC0) begin
            cls = CLS_2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            cls = CLS_3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            cls = CLS_4;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    function automatic logic [1:0] cp_width(input logic [20:0] cp);
        logic [1:0] w;
        if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
            w = 2'd0;
        end else if ((cp >= 21'h1100 && cp <= 21'h11FF) ||
                     (cp >= 21'h3130 && cp <= 21'h318F) ||
                     (cp >= 21'hAC00 && cp <= 21'hD7A3)) begin
            w = 2'd2;
        end else if ((cp >= 21'h2E80 && cp <= 21'hA4CF) ||
                     (cp >= 21'hF900 && cp <= 21'hFAFF) ||
                     (cp >= 21'hFE10 && cp <= 21'hFE19) ||
                     (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
                     (cp >= 21'hFF01 && cp <= 21'hFF60) ||
                     (cp >= 21'hFFE0 && cp <= 21'hFFE6)) begin
            w = 2'd2;
        end else begin
            w = 2'd1;
        end
        return w;
    endfunction

    // Assemble a code point from a sequence starting at b[0]
    function automatic logic [20:0] seq_cp(input logic [3:0][7:0] b, input logic [2:0] len);
        logic [20:0] cp;
        unique case (len)
            CLS_2:   cp = {10'd0, b[0][4:0], b[1][5:0]};
            CLS_3:   cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            CLS_4:   cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: cp = {13'd0, b[0]};
        endcase
        return cp;
    endfunction

endpackage

@@ hw/rtl/u8fw_front.sv @@
`timescale 1ns / 1ps
// Front end: holds the bytes of an open sequence and splits runs into code points.
// Depends on u8fw_pkg.
module u8fw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  u8fw_pkg::t_in   i_in,
    output logic            o_push,
    output u8fw_pkg::t_entry o_entry
);
    import u8fw_pkg::*;

    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];
    logic [1:0] r_pcnt, n_pcnt;
    logic [2:0] r_slen, n_slen;

    logic [3:0][7:0] run;
    logic [2:0]      cls_in, cls1, cls2;
    logic [2:0]      fill;
    logic            seq_full, hold, three;
    t_entry          entry;

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_slen = r_slen;
        hold   = 1'b0;
        entry  = '0;
        entry.last = i_in.in_last;

        cls_in   = lead_class(i_in.in_byte);
        fill     = {1'b0, r_pcnt} + 3'd1;
        seq_full = fill >= r_slen;
        three    = (r_pcnt == 2'd2);

        run[0] = r_pend[0];
        run[1] = (r_pcnt > 2'd1) ? r_pend[1] : i_in.in_byte;
        run[2] = (r_pcnt > 2'd2) ? r_pend[2] : i_in.in_byte;
        run[3] = i_in.in_byte;
        cls1   = lead_class(run[1]);
        cls2   = lead_class(run[2]);

        if (r_slen != 3'd0) begin
            if (seq_full || i_in.in_last) begin
                n_pcnt = '0;
                n_slen = '0;
                entry.bytes = run;
                if (seq_full) begin
                    entry.units[0].len = r_slen;
                    entry.units[0].wid = cp_width(seq_cp(run, r_slen));
                end else begin
                    // cut short: lead becomes '?', then re-decode what follows it
                    entry.units[0].len = 3'd1;
                    entry.units[0].wid = cp_width({13'd0, SUBST_CHAR});
                    entry.units[1].len = 3'd1;
                    if (cls1 == CLS_1) begin
                        entry.units[1].wid = cp_width({13'd0, run[1]});
                    end else if (cls1 == CLS_2 && three) begin
                        entry.units[1].len = 3'd2;
                        entry.units[1].wid =
                            cp_width(seq_cp({8'h00, 8'h00, run[2], run[1]}, CLS_2));
                    end else begin
                        entry.units[1].wid = cp_width({13'd0, SUBST_CHAR});
                    end
                    if (three && cls1 != CLS_2) begin
                        entry.units[2].len = 3'd1;
                        entry.units[2].wid = (cls2 == CLS_1) ? cp_width({13'd0, run[2]})
                                                             : cp_width({13'd0, SUBST_CHAR});
                    end
                end
            end else begin
                hold = 1'b1;
                n_pend[r_pcnt] = i_in.in_byte;
                n_pcnt = r_pcnt + 2'd1;
            end
        end else if (cls_in > CLS_1 && !i_in.in_last) begin
            hold = 1'b1;
            n_pend[0] = i_in.in_byte;
            n_pcnt = 2'd1;
            n_slen = cls_in;
        end else begin
            entry.bytes[0] = i_in.in_byte;
            entry.units[0].len = 3'd1;
            entry.units[0].wid = (cls_in == CLS_1) ? cp_width({13'd0, i_in.in_byte})
                                                   : cp_width({13'd0, SUBST_CHAR});
        end
    end

    assign o_push  = i_take && !hold;
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
            r_slen <= '0;
        end else if (i_take) begin
            r_pcnt <= n_pcnt;
            r_slen <= n_slen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pend <= n_pend;
        end
    end

endmodule

@@ hw/rtl/u8fw_queue.sv @@
`timescale 1ns / 1ps
// Short register queue that decouples the front end from the back end.
// Depends on u8fw_pkg.
module u8fw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8fw_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    output u8fw_pkg::t_entry o_entry,
    input  logic             i_pop
);
    import u8fw_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == (Q_AW)'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == (Q_AW)'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

@@ hw/rtl/u8fw_back.sv @@
`timescale 1ns / 1ps
// Back end: applies the width budget, sends kept bytes one per cycle while the result queue has room, ends strings.
// Holds the cell width register and the result skid queue; depends on u8fw_pkg.
module u8fw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_q_valid,
    input  u8fw_pkg::t_entry i_q_entry,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output u8fw_pkg::t_out   o_out
);
    import u8fw_pkg::*;

    logic [7:0]      r_cell;
    logic [7:0]      r_used;
    logic            r_cut;

    logic            r_busy;
    logic [1:0]      r_idx, r_lidx;
    logic            r_last, r_mark;
    logic [3:0][7:0] r_bytes, r_tw;
    logic [7:0]      r_pad;

    t_out              r_omem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_owp, r_orp;
    logic [OUT_AW:0]   r_ocnt;

    t_entry          e;
    logic [7:0]      lim, used_c, pad;
    logic [8:0]      sum;
    logic            cut_c;
    logic [2:0]      m;
    logic [2:0][7:0] tw_u;
    logic [3:0][7:0] tw_b, n_tw;
    logic [2:0]      bnd0, bnd1;
    logic            pop_acc, space, fire, fin, free, load, is_end;
    t_out            cur;

    assign e = i_q_entry;

    // Budget check over the units of one run, in order; a cut is sticky
    always_comb begin
        lim = (32'(r_cell) > MAX_CELL_WIDTH) ? 8'(MAX_CELL_WIDTH) : r_cell;
        used_c = r_used;
        cut_c  = r_cut;
        m      = '0;
        sum    = '0;
        tw_u   = '0;
        for (int k = 0; k < 3; k++) begin
            sum = {1'b0, used_c} + {7'd0, e.units[k].wid};
            if (e.units[k].len != 3'd0 && !cut_c) begin
                if (lim == 8'd0 || sum > {1'b0, lim}) begin
                    cut_c = 1'b1;
                end else begin
                    used_c = sum[7:0];
                    m = m + e.units[k].len;
                end
            end
            tw_u[k] = used_c;
        end
        pad  = (used_c >= lim) ? 8'd0 : lim - used_c;
        bnd0 = e.units[0].len;
        bnd1 = e.units[0].len + e.units[1].len;
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < bnd0) begin
                tw_b[j] = tw_u[0];
            end else if (3'(j) < bnd1) begin
                tw_b[j] = tw_u[1];
            end else begin
                tw_b[j] = tw_u[2];
            end
        end
        n_tw = tw_b;
        if (m == 3'd0) begin
            n_tw[0] = used_c;
        end
    end

    assign pop_acc = i_pop && (r_ocnt != '0);
    assign space   = (r_ocnt != (OUT_AW+1)'(OUT_DEPTH)) || pop_acc;
    assign fire    = r_busy && space;
    assign fin     = fire && (r_idx == r_lidx);
    assign free    = !r_busy || fin;
    assign load    = i_q_valid && free;
    assign o_q_pop = load;

    always_comb begin
        is_end          = r_last && (r_idx == r_lidx);
        cur.out_byte    = r_mark ? 8'd0 : r_bytes[r_idx];
        cur.byte_valid  = !r_mark;
        cur.total_width = r_tw[r_idx];
        cur.pad_count   = is_end ? r_pad : 8'd0;
        cur.out_last    = is_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= CELL_WIDTH_RESET;
            r_used <= '0;
            r_cut  <= 1'b0;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cell <= i_cfg_data;
            end
            if (load) begin
                // an end of string with nothing kept still sends one marker word
                r_busy <= (m != 3'd0) || e.last;
                r_idx  <= '0;
                r_used <= e.last ? 8'd0 : used_c;
                r_cut  <= e.last ? 1'b0 : cut_c;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lidx  <= (m == 3'd0) ? 2'd0 : 2'(m - 3'd1);
            r_last  <= e.last;
            r_mark  <= (m == 3'd0);
            r_bytes <= e.bytes;
            r_tw    <= n_tw;
            r_pad   <= pad;
        end
    end

    // Result skid queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (fire) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop_acc) begin
                r_orp <= r_orp + 1'b1;
            end
            unique case ({fire, pop_acc})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_omem[r_owp] <= cur;
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_out   = r_omem[r_orp];

endmodule

@@ hw/rtl/utf8_fit_to_display_width.sv @@
`timescale 1ns / 1ps
// Usage: bytes of a UTF-8 string go in on the input queue port (push/full, payload
// i_in with in_byte and in_last). Kept bytes come out on the result queue port
// (empty/pop, payload o_out), one word per kept byte, in string order.
// The final word of a string has out_last set and carries the total width and the
// pad count; a string with nothing kept gives one marker word with byte_valid low.
// The cell width is written on the valid/ready channel, which is always ready;
// write it only while no string is in flight.
// A completed code point passes the front-to-back queue, the back end registers and
// the result queue before its first word shows. One byte per cycle goes in while
// full is low; the back end sends one word per cycle if the result queue has room.
// A four-entry queue between front and back end and a two-word result queue absorb
// bursts; when the receiver stops popping, the queues fill and full rises.
// Reset (synchronous, active low) empties both queues, closes any open
// sequence and sets the cell width to 22.
// Depends on u8fw_pkg, u8fw_front, u8fw_queue and u8fw_back.
module utf8_fit_to_display_width (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  u8fw_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output u8fw_pkg::t_out o_out,
    input  logic           valid,
    output logic           ready,
    input  logic [7:0]     i_cfg_data
);
    import u8fw_pkg::*;

    logic   take, f_push, q_valid, q_pop;
    t_entry f_entry, q_entry;

    assign take  = push && !full;
    assign ready = 1'b1;

    u8fw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in),
        .o_push  (f_push),
        .o_entry (f_entry)
    );

    u8fw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (q_pop)
    );

    u8fw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (valid && ready),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out      (o_out)
    );

endmodule

@@ hw/rtl/u8fw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the UTF-8 width fitter, bound to the top level.
// Depends on u8fw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8fw_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           empty,
    input logic           pop,
    input u8fw_pkg::t_out o_out
);
    import u8fw_pkg::*;

    `AST_NXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out), "result word changed while stalled")
    `AST_IMP(a_marker_is_last, i_clk, i_rst_n, !empty && !o_out.byte_valid, o_out.out_last, "marker word without end flag")
    `AST_IMP(a_pad_on_last, i_clk, i_rst_n, !empty && o_out.pad_count != 8'd0, o_out.out_last, "pad count on a word that is not last")
    `AST_IMP(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n), empty, "result queue not empty after reset")

endmodule

bind utf8_fit_to_display_width u8fw_checker u_chk (.*);

@@ verif/utf8_fit_to_display_width_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for utf8_fit_to_display_width: drives UTF-8 strings with random
// gaps and result stalls, predicts every word and compares it field by field.
// Depends on u8fw_pkg and the utf8_fit_to_display_width RTL only.
module utf8_fit_to_display_width_test;
    import u8fw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LONG_HOLD     = 150;
    localparam int TARGET_BYTES  = 210;
    localparam int CALM_BYTES    = 170;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_BYTE, ROW_CELLS} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] data;
        bit         last;
        bit         typed;
        t_out       want;
    } t_plan_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in        i_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out       o_out;
    logic       valid = 1'b0;
    logic       ready;
    logic [7:0] i_cfg_data = 8'd0;

    // fitter state as predicted
    logic [7:0] held [3];
    int         held_n = 0;
    int         want_len = 0;
    int         cols_used = 0;
    bit         cut_off = 1'b0;
    logic [7:0] cell_cols = CELL_WIDTH_RESET;

    t_out       step_words [$];
    t_out       exp_words [$];
    t_plan_row  plan [$];
    logic [7:0] text_bytes [$];

    int         mismatches = 0;
    int         cycle_cnt = 0;
    int         counted = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;

    utf8_fit_to_display_width u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .valid      (valid),
        .ready      (ready),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Append to the tail of the predicted words of one step
    function automatic void put_step(input t_out w);
        step_words.insert(step_words.size(), w);
    endfunction

    // Append one byte to the text being built
    function automatic void put_text(input logic [7:0] v);
        text_bytes.insert(text_bytes.size(), v);
    endfunction

    function automatic logic [2:0] byte_class(input logic [7:0] c);
        logic [2:0] cls;
        casez (c)
            8'b0???????: cls = CLS_1;
            8'b110?????: cls = CLS_2;
            8'b1110????: cls = CLS_3;
            8'b11110???: cls = CLS_4;
            default:     cls = CLS_BAD;
        endcase
        return cls;
    endfunction

    function automatic int glyph_columns(input logic [20:0] cp);
        if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F)) return 0;
        // Hangul jamo, compatibility jamo and syllables
        if ((cp inside {[21'h1100:21'h11FF], [21'h3130:21'h318F], [21'hAC00:21'hD7A3]}))
            return 2;
        // CJK, compatibility ideographs, vertical and fullwidth forms
        if ((cp inside {[21'h2E80:21'hA4CF], [21'hF900:21'hFAFF], [21'hFE10:21'hFE19],
                        [21'hFE30:21'hFE6F], [21'hFF01:21'hFF60], [21'hFFE0:21'hFFE6]}))
            return 2;
        return 1;
    endfunction

    function automatic void place_unit(input logic [7:0] b [4], input int start,
                                       input int len, input logic [20:0] cp);
        int w;
        if (cut_off) return;
        w = glyph_columns(cp);
        if (cell_cols == 8'd0 || cols_used + w > int'(cell_cols)) begin
            cut_off = 1'b1;
            return;
        end
        cols_used += w;
        for (int j = 0; j < len && step_words.size() < 4; j++) begin
            put_step(t_out'{b[start + j], 1'b1, 8'(cols_used), 8'd0, 1'b0});
        end
    endfunction

    function automatic void decode_chunk(input logic [7:0] b [4], input int n);
        int i;
        int len;
        logic [20:0] cp;
        i = 0;
        while (i < n) begin
            len = int'(byte_class(b[i]));
            if (len != int'(CLS_BAD) && i + len <= n) begin
                case (3'(len))
                    CLS_2:   cp = {10'd0, b[i][4:0], b[i+1][5:0]};
                    CLS_3:   cp = {5'd0, b[i][3:0], b[i+1][5:0], b[i+2][5:0]};
                    CLS_4:   cp = {b[i][2:0], b[i+1][5:0], b[i+2][5:0], b[i+3][5:0]};
                    default: cp = {13'd0, b[i]};
                endcase
                place_unit(b, i, len, cp);
                i += len;
            end else begin
                // bad lead or sequence cut short: one byte as '?'
                place_unit(b, i, 1, 21'h3F);
                i += 1;
            end
        end
    endfunction

    function automatic void predict_byte(input t_in item);
        logic [7:0] chunk [4];
        int n;
        int len;
        int pad;
        t_out tail;
        step_words.delete();
        foreach (chunk[k]) chunk[k] = 8'd0;
        if (want_len != 0) begin
            if (held_n + 1 >= want_len || item.in_last) begin
                n = 0;
                for (int j = 0; j < held_n && j < 3; j++) begin
                    chunk[n] = held[j];
                    n++;
                end
                chunk[n] = item.in_byte;
                n++;
                held_n = 0;
                want_len = 0;
                decode_chunk(chunk, n);
            end else begin
                if (held_n < 3) held[held_n] = item.in_byte;
                held_n++;
            end
        end else begin
            len = int'(byte_class(item.in_byte));
            if (len > 1 && !item.in_last) begin
                held[0] = item.in_byte;
                held_n = 1;
                want_len = len;
            end else begin
                chunk[0] = item.in_byte;
                decode_chunk(chunk, 1);
            end
        end
        if (item.in_last) begin
            pad = (cols_used >= int'(cell_cols)) ? 0 : int'(cell_cols) - cols_used;
            if (step_words.size() == 0)
                put_step(t_out'{8'd0, 1'b0, 8'(cols_used), 8'd0, 1'b0});
            tail = step_words[step_words.size() - 1];
            tail.pad_count = 8'(pad);
            tail.out_last = 1'b1;
            step_words[step_words.size() - 1] = tail;
            held_n = 0;
            want_len = 0;
            cols_used = 0;
            cut_off = 1'b0;
        end
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [7:0] data,
                                    input bit last, input bit typed, input t_out want);
        t_plan_row row;
        row = '{kind, data, last, typed, want};
        plan.insert(plan.size(), row);
    endfunction

    function automatic void add_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_text(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_text({3'b110, cp[10:6]});
            put_text({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_text({4'b1110, cp[15:12]});
            put_text({2'b10, cp[11:6]});
            put_text({2'b10, cp[5:0]});
        end else begin
            put_text({5'b11110, cp[20:18]});
            put_text({2'b10, cp[17:12]});
            put_text({2'b10, cp[11:6]});
            put_text({2'b10, cp[5:0]});
        end
    endfunction

    // Mostly well-formed characters of every width class, some noise and broken sequences
    function automatic void build_text(input int n_chars);
        int pick;
        int conts;
        text_bytes.delete();
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                put_text(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 35) begin
                put_text(($urandom_range(0, 3) == 0) ? 8'h7F
                         : 8'($urandom_range(0, 8'h1F)));
            end else if (pick < 45) begin
                add_cp(21'($urandom_range(21'h80, 21'h7FF)));
            end else if (pick < 60) begin
                case ($urandom_range(0, 4))
                    0:       add_cp(21'(21'hAC00 + $urandom_range(0, 21'h2BA3)));
                    1:       add_cp(21'(21'h4E00 + $urandom_range(0, 21'h51FF)));
                    2:       add_cp(21'(21'hFF01 + $urandom_range(0, 21'h5F)));
                    3:       add_cp(21'(21'h1100 + $urandom_range(0, 21'hFF)));
                    default: add_cp(21'(21'hFE00 + $urandom_range(0, 21'h1FF)));
                endcase
            end else if (pick < 70) begin
                add_cp(21'($urandom_range(21'h800, 21'hFFFF)));
            end else if (pick < 78) begin
                add_cp(21'($urandom_range(21'h10000, 21'h10FFFF)));
            end else if (pick < 88) begin
                put_text(8'($urandom_range(0, 255)));
            end else begin
                // lead byte with too few continuation bytes
                case ($urandom_range(0, 2))
                    0: begin
                        put_text(8'($urandom_range(8'hC0, 8'hDF)));
                        conts = 0;
                    end
                    1: begin
                        put_text(8'($urandom_range(8'hE0, 8'hEF)));
                        conts = $urandom_range(0, 1);
                    end
                    default: begin
                        put_text(8'($urandom_range(8'hF0, 8'hF7)));
                        conts = $urandom_range(0, 2);
                    end
                endcase
                repeat (conts) put_text(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
    endfunction

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input logic [7:0] b, input bit last, input bit typed, input t_out want);
        push <= 1'b1;
        i_in <= t_in'{b, last};
        do @(posedge i_clk); while (full);
        predict_byte(t_in'{b, last});
        if (typed) begin
            exp_words.insert(exp_words.size(), want);
        end else begin
            foreach (step_words[k]) exp_words.insert(exp_words.size(), step_words[k]);
        end
        counted++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input bit gaps);
        for (int k = 0; k < text_bytes.size(); k++) begin
            if (gaps) sender_gap();
            offer(text_bytes[k], k == text_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    // Hold the input idle until every word is out and the back end has gone quiet
    task automatic settle();
        push <= 1'b0;
        while (exp_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cells(input logic [7:0] cols);
        valid <= 1'b1;
        i_cfg_data <= cols;
        do @(posedge i_clk); while (!ready);
        cell_cols = cols;
        @(negedge i_clk);
        valid <= 1'b0;
    endtask

    function automatic void note_miss(input string what, input t_out want, input t_out got);
        if (mismatches < MAX_REPORTS) begin
            $write("%s: expected byte %h valid %b width %0d pad %0d last %b",
                   what, want.out_byte, want.byte_valid, want.total_width,
                   want.pad_count, want.out_last);
            $display(", got byte %h valid %b width %0d pad %0d last %b",
                     got.out_byte, got.byte_valid, got.total_width,
                     got.pad_count, got.out_last);
        end
        mismatches++;
    endfunction

    always begin : result_drain
        @(negedge i_clk);
        if (hold_req) begin
            hold_req = 1'b0;
            pop <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge i_clk);
        end else if (calm || $urandom_range(0, 3) != 0) begin
            pop <= 1'b1;
        end else begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : word_check
        t_out got;
        t_out want;
        if (i_rst_n && pop && !empty) begin
            got = o_out;
            if (exp_words.size() == 0) begin
                note_miss("unexpected word", '0, got);
            end else begin
                want = exp_words.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.total_width !== want.total_width ||
                    got.pad_count !== want.pad_count || got.out_last !== want.out_last)
                    note_miss("word mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int strings;
        logic [7:0] cols;

        // cell width 22 after reset
        add_row(ROW_BYTE, 8'h41, 1, 1, t_out'{8'h41, 1'b1, 8'd1, 8'd21, 1'b1});
        add_row(ROW_BYTE, 8'h00, 1, 1, t_out'{8'h00, 1'b1, 8'd0, 8'd22, 1'b1});
        add_row(ROW_BYTE, 8'hFF, 1, 1, t_out'{8'hFF, 1'b1, 8'd1, 8'd21, 1'b1});
        // Hangul syllable then ASCII
        add_row(ROW_BYTE, 8'hEA, 0, 0, '0);
        add_row(ROW_BYTE, 8'hB0, 0, 0, '0);
        add_row(ROW_BYTE, 8'h80, 0, 0, '0);
        add_row(ROW_BYTE, 8'h5A, 1, 0, '0);
        // four-byte sequence closing the string
        add_row(ROW_BYTE, 8'hF0, 0, 0, '0);
        add_row(ROW_BYTE, 8'h9F, 0, 0, '0);
        add_row(ROW_BYTE, 8'h98, 0, 0, '0);
        add_row(ROW_BYTE, 8'h80, 1, 0, '0);
        // three-byte sequence cut short by the end of the string
        add_row(ROW_BYTE, 8'hE4, 0, 0, '0);
        add_row(ROW_BYTE, 8'hB8, 1, 0, '0);
        // C1 control code in two bytes, width zero
        add_row(ROW_BYTE, 8'hC2, 0, 0, '0);
        add_row(ROW_BYTE, 8'h80, 1, 0, '0);
        // continuation byte not checked
        add_row(ROW_BYTE, 8'hC3, 0, 0, '0);
        add_row(ROW_BYTE, 8'h41, 1, 0, '0);
        // zero width drops everything
        add_row(ROW_CELLS, 8'd0, 0, 0, '0);
        add_row(ROW_BYTE, 8'h42, 1, 1, t_out'{8'h00, 1'b0, 8'd0, 8'd0, 1'b1});
        add_row(ROW_CELLS, 8'd255, 0, 0, '0);
        add_row(ROW_BYTE, 8'h78, 1, 1, t_out'{8'h78, 1'b1, 8'd1, 8'd254, 1'b1});
        // wide glyph does not fit one column
        add_row(ROW_CELLS, 8'd1, 0, 0, '0);
        add_row(ROW_BYTE, 8'hEA, 0, 0, '0);
        add_row(ROW_BYTE, 8'hB0, 0, 0, '0);
        add_row(ROW_BYTE, 8'h80, 1, 1, t_out'{8'h00, 1'b0, 8'd0, 8'd1, 1'b1});
        add_row(ROW_BYTE, 8'h61, 0, 0, '0);
        add_row(ROW_BYTE, 8'h62, 1, 0, '0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CELLS) begin
                settle();
                write_cells(plan[r].data);
            end else begin
                sender_gap();
                offer(plan[r].data, plan[r].last, plan[r].typed, plan[r].want);
            end
        end

        // back-pressure: receiver holds off while a long string streams in
        settle();
        write_cells(8'd40);
        hold_req = 1'b1;
        text_bytes.delete();
        repeat (30) put_text(8'($urandom_range(8'h20, 8'h7E)));
        send_text(1'b0);

        strings = 0;
        while (counted < TARGET_BYTES) begin
            if (strings % 6 == 5) begin
                settle();
                case ($urandom_range(0, 9))
                    0:       cols = 8'd0;
                    1:       cols = 8'd255;
                    2:       cols = 8'd1;
                    3:       cols = 8'd2;
                    4, 5:    cols = 8'($urandom_range(0, 255));
                    default: cols = 8'($urandom_range(3, 24));
                endcase
                write_cells(cols);
            end
            build_text($urandom_range(1, 10));
            send_text(1'b1);
            strings++;
            calm = (counted >= CALM_BYTES);
        end

        push <= 1'b0;
        while (exp_words.size() != 0) @(negedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/u8fw_pkg.sv
hw/rtl/u8fw_front.sv
hw/rtl/u8fw_queue.sv
hw/rtl/u8fw_back.sv
hw/rtl/utf8_fit_to_display_width.sv
hw/rtl/u8fw_checker.sv
verif/utf8_fit_to_display_width_test.sv
